FILE: sv/rgba_box_mip_chain_defines.svh
// ----------------------------------------------------------------------------
// rgba_box_mip_chain_defines.svh
// Assertion macros shared by the mip chain checker.
// ----------------------------------------------------------------------------
`ifndef RGBA_BOX_MIP_CHAIN_DEFINES_SVH
`define RGBA_BOX_MIP_CHAIN_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define RBMC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked while reset is high.
`define RBMC_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/rbmc_pkg.sv
// ----------------------------------------------------------------------------
// rbmc_pkg
// Shared types and constants of the RGBA box-filter mip chain.
// ----------------------------------------------------------------------------
`default_nettype none

package rbmc_pkg;

   // Field widths fixed by the word formats.
   localparam int CHAN_W      = 8;
   localparam int PAIR_W      = 9;
   localparam int SUM_W       = 10;
   localparam int LEVEL_W     = 4;
   localparam int POS_W       = 11;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_LEVEL_W = 4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_COUNT  = 2'd2;

   // Channel positions inside a pixel and a pair-sum word.
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;
   localparam int CH_ALPHA = 3;

   typedef logic [3:0][CHAN_W-1:0] pix_type;
   typedef logic [3:0][PAIR_W-1:0] pair_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [CHAN_W-1:0]  out_red;
      logic [CHAN_W-1:0]  out_green;
      logic [CHAN_W-1:0]  out_blue;
      logic [CHAN_W-1:0]  out_alpha;
      logic               run_end;
   } rsp_type;

   // Pair store access requested by a cell.
   typedef struct packed {
      logic rd;
      logic wr;
   } mem_ctrl_type;

   // Cell status seen by the top level.
   typedef struct packed {
      logic busy;
      logic emit;
      logic done;
   } cell_stat_type;

endpackage

`default_nettype wire

FILE: sv/rbmc_pair_ram.sv
// ----------------------------------------------------------------------------
// rbmc_pair_ram
// Single-port store of horizontal pair sums with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rbmc_pair_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic               rd_en,
   input  wire logic [AW-1:0]      addr,
   input  wire rbmc_pkg::pair_type wr_data,
   output rbmc_pkg::pair_type      rd_data
);
   import rbmc_pkg::*;

   pair_type mem [DEPTH];
   pair_type rd_data_ff;

   // Write and registered read share the one address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/rbmc_cell.sv
// ----------------------------------------------------------------------------
// rbmc_cell
// One level of the mip cascade: position counters, held left pixel, quad sum.
// ----------------------------------------------------------------------------
`default_nettype none

module rbmc_cell #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_LEVELS = 13,
   parameter int IDX        = 0
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                clear,
   input  wire logic [$clog2(MAX_LEVELS+1)-1:0]     nlev,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]      pw0,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]      ph0,
   input  wire logic                                tok_in_valid,
   input  wire rbmc_pkg::pix_type                   tok_in_pixel,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]        tok_in_base,
   output logic                                     tok_out_valid,
   output rbmc_pkg::pix_type                        tok_out_pixel,
   output logic [$clog2(MAX_WIDTH)-1:0]             tok_out_base,
   input  wire logic                                next_would_emit,
   output logic                                     would_emit,
   input  wire logic                                out_free,
   output rbmc_pkg::mem_ctrl_type                   mem_ctrl,
   output logic [$clog2(MAX_WIDTH)-1:0]             mem_addr,
   output rbmc_pkg::pair_type                       mem_wdata,
   input  wire rbmc_pkg::pair_type                  mem_rdata,
   output rbmc_pkg::cell_stat_type                  stat,
   output rbmc_pkg::rsp_type                        rsp_word
);
   import rbmc_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int DW = $clog2(MAX_WIDTH + 1);

   // Token phases: A decides and touches the pair store, B forms the mean.
   logic           tok_a_ff, tok_a_in;
   logic           tok_b_ff, tok_b_in;
   pix_type        pixel_ff;
   logic [AW-1:0]  base_ff;
   logic [AW-1:0]  col_ff, col_in;
   logic [AW-1:0]  row_ff, row_in;
   pix_type        held_ff;
   pair_type       pair_ff;
   logic [AW-1:0]  x_ff;
   logic [AW-1:0]  y_ff;
   logic           ph1_ff;

   logic [DW-1:0]  pw_shift, ph_shift, pw, ph, cw, ch;
   logic [DW-1:0]  col_inc, row_inc;
   logic           col_wrap, row_wrap;
   logic [AW-1:0]  col_half, row_half;
   logic           pw_is1, ph_is1;
   logic           have_pair, go_b, hold_wr, store_ok, rd_req, wr_req;
   pair_type       pair;
   logic [AW-1:0]  x, y;
   logic [AW:0]    addr_sum, base_sum;
   logic [AW-1:0]  addr;
   logic [3:0][SUM_W-1:0] sum;
   pix_type        result;
   logic           active, next_active, emit, pass;
   rsp_type        word;

   // Dimensions of this cell's input level, never below one.
   always_comb begin
      pw_shift = pw0 >> IDX;
      ph_shift = ph0 >> IDX;
      pw       = (pw_shift == '0) ? DW'(1) : pw_shift;
      ph       = (ph_shift == '0) ? DW'(1) : ph_shift;
      cw       = ((pw >> 1) == '0) ? DW'(1) : (pw >> 1);
      ch       = ((ph >> 1) == '0) ? DW'(1) : (ph >> 1);
   end

   assign active      = int'(nlev) > IDX + 1;
   assign next_active = int'(nlev) > IDX + 2;

   // Raster position advance.
   always_comb begin
      col_inc  = DW'(col_ff) + DW'(1);
      row_inc  = DW'(row_ff) + DW'(1);
      col_wrap = col_inc >= pw;
      row_wrap = row_inc >= ph;
      col_in   = col_wrap ? '0 : AW'(col_inc);
      if (col_wrap) begin
         row_in = row_wrap ? '0 : AW'(row_inc);
      end else begin
         row_in = row_ff;
      end
   end

   // Horizontal pair and the decisions taken in phase A.
   always_comb begin
      col_half  = col_ff >> 1;
      row_half  = row_ff >> 1;
      pw_is1    = pw == DW'(1);
      ph_is1    = ph == DW'(1);
      have_pair = pw_is1 || col_ff[0];
      go_b      = have_pair && (ph_is1 || row_ff[0]);
      hold_wr   = !have_pair && (DW'(col_half) < cw);
      store_ok  = have_pair && !ph_is1 && !row_ff[0] && (DW'(row_half) < ch);
      x         = pw_is1 ? '0 : col_half;
      y         = ph_is1 ? '0 : row_half;
      for (int c = 0; c < 4; c++) begin
         if (pw_is1) begin
            pair[c] = {pixel_ff[c], 1'b0};
         end else begin
            pair[c] = PAIR_W'(held_ff[c]) + PAIR_W'(pixel_ff[c]);
         end
      end
   end

   // Pair store address, wrapped into the store.
   always_comb begin
      addr_sum = (AW+1)'(base_ff) + (AW+1)'(x);
      if (addr_sum >= (AW+1)'(MAX_WIDTH)) begin
         addr = AW'(addr_sum - (AW+1)'(MAX_WIDTH));
      end else begin
         addr = AW'(addr_sum);
      end
   end

   assign rd_req      = tok_a_ff && have_pair && !ph_is1 && row_ff[0];
   assign wr_req      = tok_a_ff && store_ok;
   assign mem_ctrl.rd = rd_req;
   assign mem_ctrl.wr = wr_req;
   assign mem_addr    = (rd_req || wr_req) ? addr : '0;
   assign mem_wdata   = wr_req ? pair : '0;

   // Phase B: quad sum and truncated mean.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         if (ph1_ff) begin
            sum[c] = {pair_ff[c], 1'b0};
         end else begin
            sum[c] = SUM_W'(mem_rdata[c]) + SUM_W'(pair_ff[c]);
         end
         result[c] = sum[c][SUM_W-1:2];
      end
   end

   assign emit = tok_b_ff && out_free;
   assign pass = emit && next_active;

   // Base of the next level's region in the pair store.
   always_comb begin
      base_sum = (AW+1)'(base_ff) + (AW+1)'(cw);
      if (base_sum >= (AW+1)'(MAX_WIDTH)) begin
         tok_out_base = AW'(base_sum - (AW+1)'(MAX_WIDTH));
      end else begin
         tok_out_base = AW'(base_sum);
      end
   end

   assign tok_out_valid = pass;
   assign tok_out_pixel = result;

   // A pixel entering now would produce a result at this level.
   assign would_emit = active && go_b;

   // Result word, zero unless this cell emits.
   always_comb begin
      word.level     = LEVEL_W'(IDX + 1);
      word.pos_x     = POS_W'(x_ff);
      word.pos_y     = POS_W'(y_ff);
      word.out_red   = result[CH_RED];
      word.out_green = result[CH_GREEN];
      word.out_blue  = result[CH_BLUE];
      word.out_alpha = result[CH_ALPHA];
      word.run_end   = !next_would_emit;
      rsp_word       = emit ? word : '0;
   end

   assign stat.busy = tok_a_ff || tok_b_ff;
   assign stat.emit = emit;
   assign stat.done = (tok_a_ff && !go_b) || (emit && !pass);

   assign tok_a_in = tok_in_valid;
   assign tok_b_in = (tok_a_ff && go_b) || (tok_b_ff && !out_free);

   // Control state and the per-level position and held pixel.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_a_ff <= 1'b0;
         tok_b_ff <= 1'b0;
         col_ff   <= '0;
         row_ff   <= '0;
         held_ff  <= '0;
      end else begin
         tok_a_ff <= tok_a_in;
         tok_b_ff <= tok_b_in;
         if (clear) begin
            col_ff  <= '0;
            row_ff  <= '0;
            held_ff <= '0;
         end else if (tok_a_ff) begin
            col_ff <= col_in;
            row_ff <= row_in;
            if (hold_wr) begin
               held_ff <= pixel_ff;
            end
         end
      end
   end

   // Token payload and phase A results.
   always_ff @(posedge clock) begin
      if (tok_in_valid) begin
         pixel_ff <= tok_in_pixel;
         base_ff  <= tok_in_base;
      end
      if (tok_a_ff) begin
         pair_ff <= pair;
         x_ff    <= x;
         y_ff    <= y;
         ph1_ff  <= ph_is1;
      end
   end

endmodule

`default_nettype wire

FILE: sv/rgba_box_mip_chain.sv
// ----------------------------------------------------------------------------
// rgba_box_mip_chain
// Streaming 2x2 box-filter mip cascade over RGBA8 source pixels.
// ----------------------------------------------------------------------------
//   Port group   Direction  Carries
//   req_*        in         one source pixel per word, raster order
//   rsp_*        out        one downsampled pixel per word, level and position
//   csr_*        in         write-only width, height and level count
//
// A source pixel holds the chain through both phases (pair store read, then
// mean) of each result it causes, and while it is in the cell where it stops.
// The shared pair store sets this. A stalled rsp holds the emitting cell and,
// with it, req.
// Reset is synchronous; the pair store is not cleared and is only read at
// entries written earlier in the same frame.
// ----------------------------------------------------------------------------
`default_nettype none

module rgba_box_mip_chain #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_LEVELS = 13
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire rbmc_pkg::req_type                       req_word,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output rbmc_pkg::rsp_type                            rsp_word,
   input  wire logic                                    csr_write_en,
   input  wire logic [rbmc_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [rbmc_pkg::CSR_DATA_W-1:0]         csr_data
);
   import rbmc_pkg::*;

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int DW    = $clog2(MAX_WIDTH + 1);
   localparam int LW    = $clog2(MAX_LEVELS + 1);
   localparam int NCELL = MAX_LEVELS - 1;
   localparam int CLW   = (DW > CSR_DATA_W) ? DW : CSR_DATA_W;
   localparam int RESET_DIM    = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
   localparam int RESET_LEVELS = (MAX_LEVELS < 13) ? MAX_LEVELS : 13;

   // Configuration, held clamped to the supported range.
   logic [DW-1:0]  width_ff, width_in;
   logic [DW-1:0]  height_ff, height_in;
   logic [LW-1:0]  nlev_ff, nlev_in;
   logic           run_clear;
   logic [DW-1:0]  dim_clamp;
   logic [LW-1:0]  lev_clamp;

   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_word_ff;

   logic           tok_valid [NCELL+1];
   pix_type        tok_pixel [NCELL+1];
   logic [AW-1:0]  tok_base  [NCELL+1];
   logic           would_emit [NCELL+1];

   mem_ctrl_type   cell_mem_ctrl [NCELL];
   logic [AW-1:0]  cell_mem_addr [NCELL];
   pair_type       cell_mem_wdata [NCELL];
   cell_stat_type  cell_stat [NCELL];
   rsp_type        cell_word [NCELL];

   logic           mem_rd, mem_wr;
   logic [AW-1:0]  mem_addr;
   pair_type       mem_wdata, mem_rdata;
   logic           busy_any, emit_any, done_any;
   rsp_type        emit_word;
   logic           out_free, req_accept;

   // Clamp of a written dimension and level count.
   always_comb begin
      if (csr_data == '0) begin
         dim_clamp = DW'(1);
      end else if (CLW'(csr_data) > CLW'(MAX_WIDTH)) begin
         dim_clamp = DW'(MAX_WIDTH);
      end else begin
         dim_clamp = DW'(csr_data);
      end
      if (csr_data[CSR_LEVEL_W-1:0] == '0) begin
         lev_clamp = LW'(1);
      end else if (csr_data[CSR_LEVEL_W-1:0] > CSR_LEVEL_W'(MAX_LEVELS)) begin
         lev_clamp = LW'(MAX_LEVELS);
      end else begin
         lev_clamp = LW'(csr_data[CSR_LEVEL_W-1:0]);
      end
   end

   // Register decode; a known register write restarts the frame.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      nlev_in   = nlev_ff;
      run_clear = 1'b0;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in  = dim_clamp;
               run_clear = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = dim_clamp;
               run_clear = 1'b1;
            end
            CSR_LEVEL_COUNT: begin
               nlev_in   = lev_clamp;
               run_clear = 1'b1;
            end
            default: begin
               run_clear = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DW'(RESET_DIM);
         height_ff <= DW'(RESET_DIM);
         nlev_ff   <= LW'(RESET_LEVELS);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         nlev_ff   <= nlev_in;
      end
   end

   // Input word enters the first cell when there is at least one level to build.
   assign req_stall  = reset || (busy_any && !done_any);
   assign req_accept = req_valid && !req_stall;

   assign tok_valid[0]         = req_accept && (nlev_ff > LW'(1));
   assign tok_pixel[0][CH_RED]   = req_word.red;
   assign tok_pixel[0][CH_GREEN] = req_word.green;
   assign tok_pixel[0][CH_BLUE]  = req_word.blue;
   assign tok_pixel[0][CH_ALPHA] = req_word.alpha;
   assign tok_base[0]          = '0;
   assign would_emit[NCELL]    = 1'b0;

   // Chain of level cells.
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      rbmc_cell #(
         .MAX_WIDTH  (MAX_WIDTH),
         .MAX_LEVELS (MAX_LEVELS),
         .IDX        (i)
      ) u_cell (
         .clock           (clock),
         .reset           (reset),
         .clear           (run_clear),
         .nlev            (nlev_ff),
         .pw0             (width_ff),
         .ph0             (height_ff),
         .tok_in_valid    (tok_valid[i]),
         .tok_in_pixel    (tok_pixel[i]),
         .tok_in_base     (tok_base[i]),
         .tok_out_valid   (tok_valid[i+1]),
         .tok_out_pixel   (tok_pixel[i+1]),
         .tok_out_base    (tok_base[i+1]),
         .next_would_emit (would_emit[i+1]),
         .would_emit      (would_emit[i]),
         .out_free        (out_free),
         .mem_ctrl        (cell_mem_ctrl[i]),
         .mem_addr        (cell_mem_addr[i]),
         .mem_wdata       (cell_mem_wdata[i]),
         .mem_rdata       (mem_rdata),
         .stat            (cell_stat[i]),
         .rsp_word        (cell_word[i])
      );
   end

   // At most one cell holds the token, so its requests are merged by OR.
   always_comb begin
      mem_rd    = 1'b0;
      mem_wr    = 1'b0;
      mem_addr  = '0;
      mem_wdata = '0;
      busy_any  = 1'b0;
      emit_any  = 1'b0;
      done_any  = 1'b0;
      emit_word = '0;
      for (int i = 0; i < NCELL; i++) begin
         mem_rd    = mem_rd   | cell_mem_ctrl[i].rd;
         mem_wr    = mem_wr   | cell_mem_ctrl[i].wr;
         mem_addr  = mem_addr | cell_mem_addr[i];
         mem_wdata = pair_type'(mem_wdata | cell_mem_wdata[i]);
         busy_any  = busy_any | cell_stat[i].busy;
         emit_any  = emit_any | cell_stat[i].emit;
         done_any  = done_any | cell_stat[i].done;
         emit_word = rsp_type'(emit_word | cell_word[i]);
      end
   end

   rbmc_pair_ram #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (mem_wr),
      .rd_en   (mem_rd),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

   // Output register; a cell emits only when it is free or being taken.
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = emit_any || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_any) begin
         rsp_word_ff <= emit_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

FILE: sv/rbmc_checker.sv
// ----------------------------------------------------------------------------
// rbmc_checker
// Port-level assertions for the mip chain, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgba_box_mip_chain_defines.svh"

module rbmc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire rbmc_pkg::rsp_type rsp_word
);

   // A stalled result word stays in place.
   `RBMC_ASSERT(rsp_hold_a, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word), "stalled rsp word changed")

   // While a result that is not the last of its pixel waits, no new pixel is taken.
   `RBMC_ASSERT(run_open_a, clock, reset, rsp_valid && rsp_stall && !rsp_word.run_end |-> req_stall, "req taken while a run is still open")

   // Reset empties the output register.
   `RBMC_ASSERT_ALWAYS(reset_empty_a, clock, reset |=> !rsp_valid, "rsp valid after reset")

endmodule

bind rgba_box_mip_chain rbmc_checker u_rbmc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGBA box-filter mip chain. Source pixels are
// streamed in raster order under several image sizes and level counts, and a
// bit-true predictor of the cascade queues the downsampled words that each
// pixel must cause. Every result word is compared field by field with the
// oldest queued word, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import rbmc_pkg::*;

   localparam int MAX_W         = 4096;
   localparam int MAX_LV        = 13;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 500000;

   // Index that selects no register; a write to it changes nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_stall;
   req_type                req_word     = '0;
   logic                   rsp_valid;
   logic                   rsp_stall    = 1'b0;
   rsp_type                rsp_word;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_data     = '0;

   int          fail_count  = 0;
   int          cycle_count = 0;
   bit          steady      = 1'b0;
   int unsigned send_quiet  = 0;

   // Predictor state of the cascade.
   logic [35:0]       pair_store [MAX_W];
   logic [31:0]       held_px [MAX_LV];
   int unsigned       col_cnt [MAX_LV];
   int unsigned       row_cnt [MAX_LV];
   logic [12:0]       cfg_width;
   logic [12:0]       cfg_height;
   logic [3:0]        cfg_levels;
   rsp_type           mip_expect [$];

   rgba_box_mip_chain dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   function automatic int unsigned clamp_dim(input int unsigned v);
      if (v < 1) return 1;
      if (v > MAX_W) return MAX_W;
      return v;
   endfunction

   // A write to a known register starts a new frame at every level.
   function automatic void restart_frame();
      for (int i = 0; i < MAX_LV; i++) begin
         held_px[i] = '0;
         col_cnt[i] = 0;
         row_cnt[i] = 0;
      end
   endfunction

   function automatic void apply_write(input logic [CSR_INDEX_W-1:0] idx,
                                       input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_IMAGE_WIDTH: cfg_width = data;
         CSR_IMAGE_HEIGHT: cfg_height = data;
         CSR_LEVEL_COUNT: cfg_levels = data[3:0];
         default: ;
      endcase
      if (idx != CSR_SPARE) restart_frame();
   endfunction

   // Runs one source pixel through the cascade and queues the words it causes.
   function automatic void predict_pixel(input req_type px);
      int unsigned     nlev, pw, ph, base, cw, ch, col, row, x, y, addr, m;
      logic [3:0][7:0] p;
      logic [3:0][9:0] pair;
      logic [3:0][9:0] sum;
      logic [35:0]     s;
      rsp_type         r;
      rsp_type         found [$];

      nlev = cfg_levels;
      if (nlev < 1) nlev = 1;
      if (nlev > MAX_LV) nlev = MAX_LV;
      pw = clamp_dim(cfg_width);
      ph = clamp_dim(cfg_height);
      base = 0;
      p[0] = px.red;
      p[1] = px.green;
      p[2] = px.blue;
      p[3] = px.alpha;

      for (m = 0; m + 1 < nlev; m++) begin
         cw = pw / 2;
         ch = ph / 2;
         if (cw < 1) cw = 1;
         if (ch < 1) ch = 1;
         col = col_cnt[m];
         row = row_cnt[m];

         // Advance this level's raster position, wrapping at frame end.
         if (col + 1 >= pw) begin
            col_cnt[m] = 0;
            row_cnt[m] = (row + 1 >= ph) ? 0 : row + 1;
         end else begin
            col_cnt[m] = col + 1;
         end

         // Horizontal pair: a width of one doubles the pixel.
         if (pw == 1) begin
            for (int c = 0; c < 4; c++) pair[c] = {1'b0, p[c], 1'b0};
            x = 0;
         end else if ((col & 1) != 0) begin
            for (int c = 0; c < 4; c++) pair[c] = held_px[m][8*c +: 8] + p[c];
            x = col >> 1;
         end else begin
            // An odd last column is never held.
            if ((col >> 1) < cw) held_px[m] = p;
            break;
         end

         // Vertical pair: a height of one doubles the row.
         addr = (base + x) % MAX_W;
         if (ph == 1) begin
            for (int c = 0; c < 4; c++) sum[c] = {pair[c][8:0], 1'b0};
            y = 0;
         end else if ((row & 1) != 0) begin
            s = pair_store[addr];
            for (int c = 0; c < 4; c++) sum[c] = s[9*c +: 9] + pair[c];
            y = row >> 1;
         end else begin
            // An odd last row is never stored.
            if ((row >> 1) < ch) begin
               for (int c = 0; c < 4; c++) s[9*c +: 9] = pair[c][8:0];
               pair_store[addr] = s;
            end
            break;
         end

         for (int c = 0; c < 4; c++) p[c] = sum[c][9:2];
         r.level     = 4'(m + 1);
         r.pos_x     = 11'(x);
         r.pos_y     = 11'(y);
         r.out_red   = p[0];
         r.out_green = p[1];
         r.out_blue  = p[2];
         r.out_alpha = p[3];
         r.run_end   = 1'b0;
         found.push_back(r);

         base += cw;
         pw = cw;
         ph = ch;
      end

      // Only the last word caused by this pixel carries the run end flag.
      foreach (found[i]) begin
         r = found[i];
         r.run_end = (i == found.size() - 1);
         mip_expect.push_back(r);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic flag_mismatch(input string what, input string wanted, input string seen);
      fail_count++;
      $display("%0t: %s, expected %s, actual %s", $time, what, wanted, seen);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want)
         flag_mismatch({name, " mismatch"}, $sformatf("%0d", want), $sformatf("%0d", got));
   endtask

   // Compare each accepted result word with the oldest queued word.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mip_expect.size() == 0) begin
            flag_mismatch("unexpected result word", "none", $sformatf("%p", rsp_word));
         end else begin
            want = mip_expect.pop_front();
            check_field("level", 16'(want.level), 16'(rsp_word.level));
            check_field("pos_x", 16'(want.pos_x), 16'(rsp_word.pos_x));
            check_field("pos_y", 16'(want.pos_y), 16'(rsp_word.pos_y));
            check_field("out_red", 16'(want.out_red), 16'(rsp_word.out_red));
            check_field("out_green", 16'(want.out_green), 16'(rsp_word.out_green));
            check_field("out_blue", 16'(want.out_blue), 16'(rsp_word.out_blue));
            check_field("out_alpha", 16'(want.out_alpha), 16'(rsp_word.out_alpha));
            check_field("run_end", 16'(want.run_end), 16'(rsp_word.run_end));
         end
      end
   end

   // Receiver stalls come in bursts, with quiet stretches between them.
   always @(negedge clock) begin
      int unsigned stall_left;
      int unsigned calm_left;
      if (reset || steady) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (calm_left != 0) begin
         calm_left--;
         rsp_stall <= 1'b0;
      end else begin
         case ($urandom_range(0, 9))
            0, 1: begin
               stall_left = $urandom_range(0, 16);
               rsp_stall <= 1'b1;
            end
            2: begin
               calm_left = $urandom_range(20, 150);
               rsp_stall <= 1'b0;
            end
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // Cycle limit on the whole run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic req_type random_pixel();
      req_type px;
      px.red   = pick_channel();
      px.green = pick_channel();
      px.blue  = pick_channel();
      px.alpha = pick_channel();
      return px;
   endfunction

   function automatic int unsigned pick_dim();
      case ($urandom_range(0, 11))
         0: return 0;
         1: return $urandom_range(17, 64);
         default: return $urandom_range(1, 16);
      endcase
   endfunction

   // Sends one pixel word; entered and left at a falling edge.
   task automatic send_pixel(input req_type px);
      int unsigned gap;
      gap = 0;
      if (!steady) begin
         if (send_quiet != 0) begin
            send_quiet--;
         end else begin
            case ($urandom_range(0, 11))
               0, 1: gap = $urandom_range(1, 17);
               2: send_quiet = $urandom_range(10, 60);
               default: ;
            endcase
         end
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word  <= px;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pixel(px);
      @(negedge clock);
   endtask

   // Holds the sender until every queued word has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (mip_expect.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Pixels that cause no word may still be in the chain; give them time.
   task automatic settle();
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      apply_write(idx, data);
      @(negedge clock);
   endtask

   task automatic configure(input int unsigned w, input int unsigned h, input int unsigned lv);
      settle();
      write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h));
      write_reg(CSR_LEVEL_COUNT, CSR_DATA_W'(lv));
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset configuration: a full-size image whose first row causes nothing.
   task automatic test_reset_defaults();
      send_pixel(req_type'(32'h0000_0000));
      send_pixel(req_type'(32'hFFFF_FFFF));
   endtask

   // Two 2x2 frames back to back; the counters wrap between them.
   task automatic test_tiny_frames();
      configure(2, 2, 2);
      repeat (4) send_pixel(req_type'(32'hFFFF_FFFF));
      repeat (4) send_pixel(random_pixel());
   endtask

   // Zero width and height act as one, and an oversized level count
   // saturates, so each pixel runs the whole chain of 1x1 levels.
   task automatic test_single_pixel_chain();
      configure(0, 0, 15);
      send_pixel(req_type'(32'hFFFF_FFFF));
      send_pixel(random_pixel());
   endtask

   // A level count of zero leaves only the source level: no words at all.
   task automatic test_no_levels();
      settle();
      write_reg(CSR_LEVEL_COUNT, 13'h1FF0);
      send_pixel(req_type'(32'hFFFF_FFFF));
   endtask

   // Oversized width saturates; a height of one emits on every pair.
   task automatic test_wide_saturation();
      configure(8191, 1, 2);
      repeat (4) send_pixel(random_pixel());
   endtask

   // The spare index leaves the frame running; a real write restarts it.
   task automatic test_restart_on_write();
      configure(3, 4096, 3);
      repeat (4) send_pixel(random_pixel());
      settle();
      write_reg(CSR_SPARE, CSR_DATA_W'($urandom));
      repeat (2) send_pixel(random_pixel());
      settle();
      write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(3));
      repeat (5) send_pixel(random_pixel());
   endtask

   // Random sizes and level counts, mostly whole frames with a partial tail.
   task automatic test_random_frames(input int unsigned budget);
      int unsigned sent, area, total;
      logic [2:0]  pick;
      sent = 0;
      while (sent < budget) begin
         settle();
         pick = 3'($urandom_range(1, 7));
         if (pick[0]) write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'(pick_dim()));
         if (pick[1]) write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(pick_dim()));
         if (pick[2]) begin
            if ($urandom_range(0, 7) == 0)
               write_reg(CSR_LEVEL_COUNT, {9'($urandom), 4'($urandom_range(0, 15))});
            else
               write_reg(CSR_LEVEL_COUNT, {9'($urandom), 4'($urandom_range(1, 13))});
         end
         if ($urandom_range(0, 5) == 0) write_reg(CSR_SPARE, CSR_DATA_W'($urandom));

         area  = clamp_dim(cfg_width) * clamp_dim(cfg_height);
         total = area * $urandom_range(1, 3) + $urandom_range(0, area - 1);
         if (total > 120) total = 120;
         if (total > budget - sent) total = budget - sent;
         for (int unsigned i = 0; i < total; i++) begin
            send_pixel(random_pixel());
            if ($urandom_range(0, 79) == 0) drain_results();
         end
         sent += total;
      end
   endtask

   // One whole frame at full rate with no idling on either side.
   task automatic test_steady_stream();
      settle();
      steady = 1'b1;
      write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'(12));
      write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'(6));
      write_reg(CSR_LEVEL_COUNT, CSR_DATA_W'(5));
      repeat (72) send_pixel(random_pixel());
   endtask

   initial begin
      // Predictor state after reset.
      for (int i = 0; i < MAX_W; i++) pair_store[i] = '0;
      restart_frame();
      cfg_width  = 13'd4096;
      cfg_height = 13'd4096;
      cfg_levels = 4'd13;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_tiny_frames();
      test_single_pixel_chain();
      test_no_levels();
      test_wide_saturation();
      test_restart_on_write();
      test_random_frames(330);
      test_steady_stream();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mip_expect.size() != 0)
         flag_mismatch("result words never delivered",
                       $sformatf("%0d more", mip_expect.size()), "none");
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
